// ===== src/vcb_pkg.sv =====
package vcb_pkg;

	// low bits of total_length that are kept
	localparam int LENGTH_BITS = 32;

	localparam int MIN_BLOCK_BYTES = 8;
	localparam int FIELD_BYTES = 4;
	localparam int MIN_COMMENT_BYTES = 3;

	localparam logic [7:0] KEY_CHAR_MIN = 8'h20;
	localparam logic [7:0] KEY_CHAR_MAX = 8'h7D;
	localparam logic [7:0] ASCII_EQ = 8'h3D;
	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_VLEN,
		PH_VEND,
		PH_COUNT,
		PH_CLEN,
		PH_KEY,
		PH_VALUE,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		CLS_IGNORED  = 3'd0,
		CLS_VLEN     = 3'd1,
		CLS_VENDOR   = 3'd2,
		CLS_COUNT    = 3'd3,
		CLS_CLEN     = 3'd4,
		CLS_KEY      = 3'd5,
		CLS_SEP      = 3'd6,
		CLS_VALUE    = 3'd7
	} byte_class_t;

	typedef enum logic [2:0] {
		ST_BUSY    = 3'd0,
		ST_OK      = 3'd1,
		ST_CROPPED = 3'd2,
		ST_SHORT   = 3'd3,
		ST_NOSEP   = 3'd4,
		ST_NOVALUE = 3'd5,
		ST_BADKEY  = 3'd6
	} status_t;

	typedef struct packed {
		phase_t                   phase;
		status_t                  status;
		logic [31:0]              acc;
		logic [1:0]               idx;
		logic [LENGTH_BITS-1:0]   left;
		logic [31:0]              run;
		logic [31:0]              cnt;
		logic                     off0;
		logic                     bad;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:  PH_IDLE,
		status: ST_BUSY,
		acc:    '0,
		idx:    '0,
		left:   '0,
		run:    '0,
		cnt:    '0,
		off0:   1'b1,
		bad:    1'b0
	};

endpackage

// ===== src/vcb_step.sv =====
module vcb_step
	import vcb_pkg::*;
(
	input  state_t       cur,
	input  logic         start_req,
	input  logic [7:0]   in_byte,
	input  logic [31:0]  total_length,
	output state_t       nxt,
	output logic [7:0]   out_byte,
	output byte_class_t  byte_class,
	output logic         comment_end
);

	// after the last count byte or a good comment: next comment, done or cropped
	function automatic state_t next_comment(state_t s);
		state_t r;
		r = s;
		if (s.cnt == 32'd0) begin
			r.phase = PH_DONE;
			r.status = ST_OK;
		end else if (s.left < LENGTH_BITS'(FIELD_BYTES)) begin
			r.phase = PH_DONE;
			r.status = ST_CROPPED;
		end else begin
			r.phase = PH_CLEN;
		end
		return r;
	endfunction

	state_t                  st;
	logic [31:0]             acc_full;
	logic                    field_done;
	logic [LENGTH_BITS-1:0]  left_dec;
	logic [31:0]             run_dec;

	always_comb begin
		st = cur;
		out_byte = in_byte;
		byte_class = CLS_IGNORED;
		comment_end = 1'b0;

		if (start_req) begin
			st = STATE_RESET;
			st.left = total_length[LENGTH_BITS-1:0];
			if (st.left < LENGTH_BITS'(MIN_BLOCK_BYTES)) begin
				st.phase = PH_DONE;
				st.status = ST_CROPPED;
			end else begin
				st.phase = PH_VLEN;
			end
		end

		// little-endian length field assembly
		acc_full = st.acc | (32'(in_byte) << {st.idx, 3'b000});
		field_done = (st.idx == 2'd3);
		left_dec = st.left - LENGTH_BITS'(1);
		run_dec = st.run - 32'd1;

		case (st.phase)
			PH_VLEN: begin
				byte_class = CLS_VLEN;
				st.left = left_dec;
				st.idx = st.idx + 2'd1;
				st.acc = field_done ? 32'd0 : acc_full;
				if (field_done) begin
					if ((33'(acc_full) + 33'(FIELD_BYTES)) > 33'(left_dec)) begin
						st.phase = PH_DONE;
						st.status = ST_CROPPED;
					end else begin
						st.run = acc_full;
						st.phase = (acc_full != 32'd0) ? PH_VEND : PH_COUNT;
					end
				end
			end
			PH_VEND: begin
				byte_class = CLS_VENDOR;
				st.left = left_dec;
				st.run = run_dec;
				if (run_dec == 32'd0) begin
					st.phase = PH_COUNT;
				end
			end
			PH_COUNT: begin
				byte_class = CLS_COUNT;
				st.left = left_dec;
				st.idx = st.idx + 2'd1;
				st.acc = field_done ? 32'd0 : acc_full;
				if (field_done) begin
					st.cnt = acc_full;
					st = next_comment(st);
				end
			end
			PH_CLEN: begin
				byte_class = CLS_CLEN;
				st.left = left_dec;
				st.idx = st.idx + 2'd1;
				st.acc = field_done ? 32'd0 : acc_full;
				if (field_done) begin
					if (33'(acc_full) > 33'(left_dec)) begin
						st.phase = PH_DONE;
						st.status = ST_CROPPED;
					end else if (acc_full < 32'(MIN_COMMENT_BYTES)) begin
						st.phase = PH_DONE;
						st.status = ST_SHORT;
					end else begin
						st.run = acc_full;
						st.off0 = 1'b1;
						st.bad = 1'b0;
						st.phase = PH_KEY;
					end
				end
			end
			PH_KEY: begin
				st.left = left_dec;
				st.run = run_dec;
				if (!st.off0 && in_byte == ASCII_EQ) begin
					byte_class = CLS_SEP;
					if (run_dec == 32'd0) begin
						st.phase = PH_DONE;
						st.status = ST_NOVALUE;
					end else if (st.bad) begin
						st.phase = PH_DONE;
						st.status = ST_BADKEY;
					end else begin
						st.phase = PH_VALUE;
					end
				end else begin
					byte_class = CLS_KEY;
					if (!(in_byte inside {[KEY_CHAR_MIN:KEY_CHAR_MAX]}) ||
						in_byte == ASCII_EQ) begin
						st.bad = 1'b1;
					end
					if (in_byte inside {[ASCII_UPPER_A:ASCII_UPPER_Z]}) begin
						out_byte = in_byte + CASE_OFFSET;
					end
					st.off0 = 1'b0;
					if (run_dec == 32'd0) begin
						st.phase = PH_DONE;
						st.status = ST_NOSEP;
					end
				end
			end
			PH_VALUE: begin
				byte_class = CLS_VALUE;
				st.left = left_dec;
				st.run = run_dec;
				if (run_dec == 32'd0) begin
					comment_end = 1'b1;
					st.cnt = st.cnt - 32'd1;
					st = next_comment(st);
				end
			end
			default: begin
			end
		endcase

		nxt = st;
	end

endmodule

// ===== src/vorbis_comment_block_parser_top.sv =====
// vorbis comment block parser
//
// bytes of a comment block enter on the item channel (item_valid / item_stall),
// one word per byte; start_req marks the first byte of a block and carries
// total_length, the number of bytes supplied for that block
// each word gives exactly one result word on the result channel
// (result_valid / result_stall): the byte (key bytes lowercased), its class,
// the running status and a flag on the last byte of every good comment
// a word accepted sits in the input stage, is processed by the step logic and
// is then loaded into the result register, which drives result_valid
// throughput: one word per cycle while the receiver does not stall; the state
// update (counters and compares of vcb_step) lies between the input and
// result registers
// when the receiver stalls, the result register holds and the input stage
// holds too, so item_stall rises only while both stages are full and stalled
// reset clears all valid bits and puts the parser in idle with status busy;
// before the first start every byte comes back ignored with status busy
module vorbis_comment_block_parser_top
	import vcb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_stall,
	input  logic         start_req,
	input  logic [7:0]   in_byte,
	input  logic [31:0]  total_length,
	output logic         result_valid,
	input  logic         result_stall,
	output logic [7:0]   out_byte,
	output logic [2:0]   byte_class,
	output logic [2:0]   status,
	output logic         comment_end
);

	// input stage
	logic         valid_s1;
	logic         start_s1;
	logic [7:0]   byte_s1;
	logic [31:0]  total_s1;

	// result stage
	logic         valid_s2;
	logic [7:0]   byte_s2;
	byte_class_t  class_s2;
	status_t      status_s2;
	logic         cend_s2;

	// parse state
	state_t       state_q;
	state_t       state_nxt;

	logic [7:0]   step_byte;
	byte_class_t  step_class;
	logic         step_cend;

	logic         advance;
	logic         item_take;

	// input stage moves on when the result register is free or being drained
	assign advance = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign item_take = item_valid && !item_stall;

	vcb_step u_step (
		.cur          (state_q),
		.start_req    (start_s1),
		.in_byte      (byte_s1),
		.total_length (total_s1),
		.nxt          (state_nxt),
		.out_byte     (step_byte),
		.byte_class   (step_class),
		.comment_end  (step_cend)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			start_s1 <= start_req;
			byte_s1 <= in_byte;
			total_s1 <= total_length;
		end
	end

	// parse state only changes when a byte is actually processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_s2 <= step_byte;
			class_s2 <= step_class;
			status_s2 <= state_nxt.status;
			cend_s2 <= step_cend;
		end
	end

	assign result_valid = valid_s2;
	assign out_byte = byte_s2;
	assign byte_class = class_s2;
	assign status = status_s2;
	assign comment_end = cend_s2;

endmodule

// ===== tb/vorbis_comment_block_parser_top_test.sv =====
module vorbis_comment_block_parser_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import vcb_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 12;
	localparam int WORD_TARGET = 1450;
	// receiver hold-off, long enough to back the parser up into its input
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER_RESULTS = 300;
	// margin after the last result word is taken
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS = 30;
	// slowest legal run is about 2.2 ms, this is several times that
	localparam int RUN_LIMIT_NS = 20_000_000;
	localparam logic [63:0] LEN_MASK = (64'd1 << LENGTH_BITS) - 64'd1;
	// harmless key character used to replace a stray '=' or a separator
	localparam logic [7:0] KEY_FILL = 8'h5F;

	// one input word, with an optional typed-in expectation
	typedef struct packed {
		logic        sof;
		logic [7:0]  data;
		logic [31:0] total;
		logic        fixed;
		logic [7:0]  want_byte;
		byte_class_t want_class;
		status_t     want_status;
		logic        want_end;
	} feed_word_t;

	// one result word as the parser should give it
	typedef struct packed {
		logic [7:0]  data;
		byte_class_t cls;
		status_t     st;
		logic        cend;
	} parsed_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        start_req = 1'b0;
	logic [7:0]  in_byte = 8'h00;
	logic [31:0] total_length = 32'h0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [7:0]  out_byte;
	logic [2:0]  byte_class;
	logic [2:0]  status;
	logic        comment_end;

	vorbis_comment_block_parser_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.start_req(start_req),
		.in_byte(in_byte),
		.total_length(total_length),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_byte(out_byte),
		.byte_class(byte_class),
		.status(status),
		.comment_end(comment_end)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// directed words, every expectation here can be read straight off the format
	localparam feed_word_t DIRECTED [15] = '{
		// byte before any start: ignored, still busy
		'{1'b0, 8'hFF, 32'h0, 1'b1, 8'hFF, CLS_IGNORED, ST_BUSY, 1'b0},
		// block shorter than the two length fields: cropped on its start byte
		'{1'b1, 8'h00, 32'd7, 1'b1, 8'h00, CLS_IGNORED, ST_CROPPED, 1'b0},
		// largest total with an all-ones vendor length: cropped on the fourth byte
		'{1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, CLS_VLEN, ST_BUSY, 1'b0},
		'{1'b0, 8'hFF, 32'h0, 1'b1, 8'hFF, CLS_VLEN, ST_BUSY, 1'b0},
		'{1'b0, 8'hFF, 32'h0, 1'b1, 8'hFF, CLS_VLEN, ST_BUSY, 1'b0},
		'{1'b0, 8'hFF, 32'h0, 1'b1, 8'hFF, CLS_VLEN, ST_CROPPED, 1'b0},
		// smallest legal block: empty vendor, no comments, ok on the last count byte
		'{1'b1, 8'h00, 32'd8, 1'b1, 8'h00, CLS_VLEN, ST_BUSY, 1'b0},
		'{1'b0, 8'h00, 32'h0, 1'b1, 8'h00, CLS_VLEN, ST_BUSY, 1'b0},
		'{1'b0, 8'h00, 32'h0, 1'b1, 8'h00, CLS_VLEN, ST_BUSY, 1'b0},
		'{1'b0, 8'h00, 32'h0, 1'b1, 8'h00, CLS_VLEN, ST_BUSY, 1'b0},
		'{1'b0, 8'h00, 32'h0, 1'b1, 8'h00, CLS_COUNT, ST_BUSY, 1'b0},
		'{1'b0, 8'h00, 32'h0, 1'b1, 8'h00, CLS_COUNT, ST_BUSY, 1'b0},
		'{1'b0, 8'h00, 32'h0, 1'b1, 8'h00, CLS_COUNT, ST_BUSY, 1'b0},
		'{1'b0, 8'h00, 32'h0, 1'b1, 8'h00, CLS_COUNT, ST_OK, 1'b0},
		// trailing byte after done: ignored and not lowercased
		'{1'b0, 8'h5A, 32'hFFFF_FFFF, 1'b1, 8'h5A, CLS_IGNORED, ST_OK, 1'b0}
	};

	feed_word_t byte_feed [$];
	parsed_t    expected_bytes [$];

	// scratch for building one block
	logic [7:0] blk_bytes [$];
	int         key_spots [$];
	int         sep_spots [$];
	int         clen_spots [$];

	int         blocks_built = 0;
	int         results_seen = 0;
	int         mismatches = 0;
	logic [7:0] class_seen = '0;
	logic [6:0] code_seen = '0;

	// idle / stall pacing
	int         gap_calm = 0;
	int         stall_run = 0;
	int         stall_calm = 0;
	bit         hold_off = 1'b0;
	bit         hold_done = 1'b0;

	// parser state, kept apart from the block
	phase_t      ph;
	status_t     final_code;
	logic [31:0] acc;
	logic [1:0]  acc_idx;
	logic [63:0] block_left;    // wide so length + 4 cannot wrap
	logic [31:0] run_left;
	logic [31:0] comments_left;
	logic        at_key_start;
	logic        key_tainted;

	task automatic clear_parse();
		ph = PH_IDLE;
		final_code = ST_BUSY;
		acc = '0;
		acc_idx = '0;
		block_left = '0;
		run_left = '0;
		comments_left = '0;
		at_key_start = 1'b1;
		key_tainted = 1'b0;
	endtask

	task automatic end_parse(input status_t code);
		ph = PH_DONE;
		final_code = code;
	endtask

	// little-endian 32-bit field, full on its fourth byte
	task automatic take_length_byte(input logic [7:0] b, output logic full,
			output logic [31:0] val);
		acc = acc | (32'(b) << (8 * acc_idx));
		acc_idx = acc_idx + 2'd1;
		full = (acc_idx == 2'd0);
		val = acc;
		if (full)
			acc = '0;
	endtask

	task automatic next_comment_or_done();
		if (comments_left == 0)
			end_parse(ST_OK);
		else if (block_left < FIELD_BYTES)
			end_parse(ST_CROPPED);
		else
			ph = PH_CLEN;
	endtask

	// one byte through the parser, one result out
	task automatic parse_byte(input logic sof, input logic [7:0] b, input logic [31:0] tot,
			output parsed_t r);
		logic        full;
		logic [31:0] len;
		r.data = b;
		r.cls = CLS_IGNORED;
		r.cend = 1'b0;
		if (sof) begin
			clear_parse();
			block_left = {32'd0, tot} & LEN_MASK;
			if (block_left < MIN_BLOCK_BYTES)
				end_parse(ST_CROPPED);
			else
				ph = PH_VLEN;
		end
		case (ph)
		PH_VLEN: begin
			r.cls = CLS_VLEN;
			block_left--;
			take_length_byte(b, full, len);
			if (full) begin
				if ({32'd0, len} + 64'd4 > block_left)
					end_parse(ST_CROPPED);
				else begin
					run_left = len;
					ph = (len != 0) ? PH_VEND : PH_COUNT;
				end
			end
		end
		PH_VEND: begin
			r.cls = CLS_VENDOR;
			block_left--;
			run_left--;
			if (run_left == 0)
				ph = PH_COUNT;
		end
		PH_COUNT: begin
			r.cls = CLS_COUNT;
			block_left--;
			take_length_byte(b, full, len);
			if (full) begin
				comments_left = len;
				next_comment_or_done();
			end
		end
		PH_CLEN: begin
			r.cls = CLS_CLEN;
			block_left--;
			take_length_byte(b, full, len);
			if (full) begin
				if ({32'd0, len} > block_left)
					end_parse(ST_CROPPED);
				else if (len < MIN_COMMENT_BYTES)
					end_parse(ST_SHORT);
				else begin
					run_left = len;
					at_key_start = 1'b1;
					key_tainted = 1'b0;
					ph = PH_KEY;
				end
			end
		end
		PH_KEY: begin
			block_left--;
			run_left--;
			// '=' only separates from the second byte on
			if (!at_key_start && b == ASCII_EQ) begin
				r.cls = CLS_SEP;
				if (run_left == 0)
					end_parse(ST_NOVALUE);
				else if (key_tainted)
					end_parse(ST_BADKEY);
				else
					ph = PH_VALUE;
			end else begin
				r.cls = CLS_KEY;
				if (b < KEY_CHAR_MIN || b > KEY_CHAR_MAX || b == ASCII_EQ)
					key_tainted = 1'b1;
				if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z)
					r.data = b + CASE_OFFSET;
				at_key_start = 1'b0;
				if (run_left == 0)
					end_parse(ST_NOSEP);
			end
		end
		PH_VALUE: begin
			r.cls = CLS_VALUE;
			block_left--;
			run_left--;
			if (run_left == 0) begin
				r.cend = 1'b1;
				comments_left--;
				next_comment_or_done();
			end
		end
		default: ;
		endcase
		r.st = (ph == PH_DONE) ? final_code : ST_BUSY;
	endtask

	function automatic void push_word(input logic [31:0] v);
		for (int k = 0; k < FIELD_BYTES; k++)
			blk_bytes.push_back(v[8 * k +: 8]);
	endfunction

	// one comment block, mostly well formed, sometimes with one fault planted
	task automatic add_block();
		int          vlen;
		int          ncom;
		int          clen;
		int          klen;
		int          kind;
		int          extra;
		int          pick;
		logic [31:0] tot;
		logic [7:0]  c;
		feed_word_t  wd;
		blk_bytes.delete();
		key_spots.delete();
		sep_spots.delete();
		clen_spots.delete();

		// stray words between blocks: random starts, random totals, random bytes
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 5)) begin
				wd = '0;
				wd.sof = ($urandom_range(0, 3) == 0);
				wd.data = 8'($urandom_range(0, 255));
				wd.total = $urandom_range(0, 1) ? 32'($urandom_range(0, 9)) : $urandom;
				byte_feed.push_back(wd);
			end
		end

		vlen = $urandom_range(0, 6);
		ncom = $urandom_range(0, 4);
		push_word(32'(vlen));
		repeat (vlen)
			blk_bytes.push_back(8'($urandom_range(0, 255)));
		push_word(32'(ncom));
		for (int n = 0; n < ncom; n++) begin
			clen = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30) : $urandom_range(3, 10);
			klen = $urandom_range(1, clen - 2);
			// separator on the last byte now and then
			if ($urandom_range(0, 14) == 0)
				klen = clen - 1;
			clen_spots.push_back(blk_bytes.size());
			push_word(32'(clen));
			for (int k = 0; k < klen; k++) begin
				if ($urandom_range(0, 3) == 0)
					c = 8'($urandom_range(ASCII_UPPER_A, ASCII_UPPER_Z));
				else
					c = 8'($urandom_range(KEY_CHAR_MIN, KEY_CHAR_MAX));
				if (c == ASCII_EQ)
					c = KEY_FILL;
				key_spots.push_back(blk_bytes.size());
				blk_bytes.push_back(c);
			end
			sep_spots.push_back(blk_bytes.size());
			blk_bytes.push_back(ASCII_EQ);
			repeat (clen - klen - 1)
				blk_bytes.push_back(8'($urandom_range(0, 255)));
		end
		tot = blk_bytes.size();

		kind = $urandom_range(0, 19);
		case (kind)
		// declared length too small, or the supply cut short by the next start
		12: begin
			if ($urandom_range(0, 1))
				tot = $urandom_range(0, blk_bytes.size() - 1);
			else
				repeat ($urandom_range(1, blk_bytes.size() - 1))
					void'(blk_bytes.pop_back());
		end
		13: blk_bytes[$urandom_range(0, blk_bytes.size() - 1)] = 8'($urandom_range(0, 255));
		// key character out of range
		14: if (key_spots.size() > 0) begin
			pick = key_spots[$urandom_range(0, key_spots.size() - 1)];
			blk_bytes[pick] = $urandom_range(0, 1) ? 8'($urandom_range(0, KEY_CHAR_MIN - 1))
				: 8'($urandom_range(KEY_CHAR_MAX + 1, 255));
		end
		// separator dropped
		15: if (sep_spots.size() > 0)
			blk_bytes[sep_spots[$urandom_range(0, sep_spots.size() - 1)]] = KEY_FILL;
		// comment length below the minimum, or beyond the block
		16: if (clen_spots.size() > 0) begin
			pick = clen_spots[$urandom_range(0, clen_spots.size() - 1)];
			if ($urandom_range(0, 1)) begin
				blk_bytes[pick] = 8'($urandom_range(0, MIN_COMMENT_BYTES - 1));
				blk_bytes[pick + 1] = 8'h00;
				blk_bytes[pick + 2] = 8'h00;
				blk_bytes[pick + 3] = 8'h00;
			end else
				blk_bytes[pick + 3] = 8'($urandom_range(1, 255));
		end
		// '=' as the first key byte stays a key byte and taints the key
		17: if (clen_spots.size() > 0)
			blk_bytes[clen_spots[$urandom_range(0, clen_spots.size() - 1)] + FIELD_BYTES] =
				ASCII_EQ;
		// huge declared length, or a vendor or comment count out of proportion
		18: tot = $urandom;
		19: begin
			if ($urandom_range(0, 1))
				blk_bytes[FIELD_BYTES - 1] = 8'($urandom_range(1, 255));
			else
				blk_bytes[FIELD_BYTES + vlen + $urandom_range(0, FIELD_BYTES - 1)] =
					8'($urandom_range(0, 255));
		end
		default: ;
		endcase

		// trailing bytes past the structure
		if ($urandom_range(0, 2) == 0) begin
			extra = $urandom_range(1, 4);
			repeat (extra)
				blk_bytes.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1))
				tot = tot + extra;
		end

		// total only counts on the start word, elsewhere it is noise
		foreach (blk_bytes[i]) begin
			wd = '0;
			wd.sof = (i == 0);
			wd.data = blk_bytes[i];
			wd.total = (i == 0) ? tot : $urandom;
			byte_feed.push_back(wd);
		end
		blocks_built++;
	endtask

	// sender idle gaps: mostly none or short, a few long, some calm stretches
	function automatic int next_gap();
		int r;
		if (hold_off)
			return 0;
		if (gap_calm > 0) begin
			gap_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2)
			gap_calm = $urandom_range(40, 150);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 70);
	endfunction

	// receiver stalls in runs, same shape as the sender gaps
	function automatic logic next_stall();
		int r;
		if (stall_run > 0) begin
			stall_run--;
			return 1'b1;
		end
		if (stall_calm > 0) begin
			stall_calm--;
			return 1'b0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			stall_calm = $urandom_range(50, 200);
			return 1'b0;
		end
		if (r < 70)
			return 1'b0;
		if (r < 93)
			stall_run = $urandom_range(0, 2);
		else if (r < 99)
			stall_run = $urandom_range(3, 12);
		else
			stall_run = $urandom_range(30, 80);
		return 1'b1;
	endfunction

	// sender: reset, then offer every word and predict it on accept
	initial begin : send_words
		feed_word_t wd;
		parsed_t    p;
		int         gap;
		clear_parse();
		foreach (DIRECTED[i])
			byte_feed.push_back(DIRECTED[i]);
		while (byte_feed.size() < WORD_TARGET)
			add_block();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap = next_gap();
		while (byte_feed.size() > 0) begin
			wd = byte_feed.pop_front();
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			item_valid <= 1'b1;
			start_req <= wd.sof;
			in_byte <= wd.data;
			total_length <= wd.total;
			// payload holds until the word is taken
			do @(posedge clk); while (item_stall);
			parse_byte(wd.sof, wd.data, wd.total, p);
			if (wd.fixed) begin
				p.data = wd.want_byte;
				p.cls = wd.want_class;
				p.st = wd.want_status;
				p.cend = wd.want_end;
			end
			expected_bytes.push_back(p);
			gap = next_gap();
		end
		item_valid <= 1'b0;

		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d result words checked over %0d blocks, %0d mismatches",
			results_seen, blocks_built, mismatches);
		$display("byte classes seen %b, status codes seen %b", class_seen, code_seen);
		if (mismatches == 0)
			$display("vorbis_comment_block_parser_top_test OK");
		else
			$display("vorbis_comment_block_parser_top_test NOT OK");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off so the input side backs up
	initial begin : pace_results
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
				hold_off = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
				hold_done = 1'b1;
			end else
				result_stall <= next_stall();
		end
	end

	// compare each taken result word with the oldest prediction
	always @(posedge clk) begin : check_results
		parsed_t w;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result byte %02h class %0d status %0d end %0b",
						$time, out_byte, byte_class, status, comment_end);
			end else begin
				w = expected_bytes.pop_front();
				class_seen[w.cls] = 1'b1;
				code_seen[w.st] = 1'b1;
				if (out_byte !== w.data || byte_class !== w.cls || status !== w.st ||
						comment_end !== w.cend) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"%0t: expected byte %02h class %0d status %0d end %0b,",
							" got byte %02h class %0d status %0d end %0b"}, $time,
							w.data, w.cls, w.st, w.cend,
							out_byte, byte_class, status, comment_end);
				end
			end
		end
	end

	// hung handshake guard
	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("vorbis_comment_block_parser_top_test NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
src/vcb_pkg.sv
src/vcb_step.sv
src/vorbis_comment_block_parser_top.sv
tb/vorbis_comment_block_parser_top_test.sv
